### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while reset is asserted
`define BDQ_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bounded_deque: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off while reset is asserted
`define BDQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bounded_deque: next-cycle check failed");

`endif

### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and types of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Default configuration
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int ACTION_W = 3;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SHOW       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Back-end operation kinds
    localparam logic [1:0] OP_STAT  = 2'd0;  // status result only
    localparam logic [1:0] OP_WRITE = 2'd1;  // store write, then status result
    localparam logic [1:0] OP_READ  = 2'd2;  // store read, result carries data

    // Control part of one queued operation
    typedef struct packed {
        logic [1:0]          kind;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_ctl;

endpackage

### rtl/bdq_queue.sv
// ----------------------------------------------------------------------------
// bdq_queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module bdq_queue
    import bdq_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/bdq_front.sv
// ----------------------------------------------------------------------------
// bdq_front
// Accepts commands, keeps the ring front index and entry count, decides the
// status of each command and issues store operations to the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_front
    import bdq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(DEPTH),
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   o_busy,
    input  logic [ACTION_W-1:0]    i_action,
    input  logic signed [31:0]     i_value,
    input  logic                   i_full,
    output logic                   o_enq,
    output t_ctl                   o_enq_ctl,
    output logic [AW-1:0]          o_enq_addr,
    output logic [VALUE_WIDTH-1:0] o_enq_data
);

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic          r_show_active, n_show_active;
    logic [AW-1:0] r_show_addr, n_show_addr;
    logic [CW-1:0] r_show_left, n_show_left;

    logic          accept;
    logic          is_full, is_empty;
    logic [AW-1:0] front_inc, front_dec, show_inc, back_idx;
    logic [CW:0]   back_sum;
    logic [63:0]   value_wide;

    assign o_busy   = r_show_active || i_full;
    assign accept   = start && !o_busy;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Ring index arithmetic, modulo DEPTH
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign show_inc  = (r_show_addr == AW'(DEPTH - 1)) ? '0 : r_show_addr + AW'(1);
    assign back_sum  = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign back_idx  = (back_sum >= (CW+1)'(DEPTH)) ? AW'(back_sum - (CW+1)'(DEPTH))
                                                    : AW'(back_sum);

    // Keep the low VALUE_WIDTH bits of the pushed value
    assign value_wide = {32'b0, i_value};
    assign o_enq_data = value_wide[VALUE_WIDTH-1:0];

    // Command decode and show sequencing
    always_comb begin
        n_front          = r_front;
        n_count          = r_count;
        n_show_active    = r_show_active;
        n_show_addr      = r_show_addr;
        n_show_left      = r_show_left;
        o_enq            = 1'b0;
        o_enq_ctl.kind   = OP_STAT;
        o_enq_ctl.status = ST_DONE;
        o_enq_ctl.last   = 1'b1;
        o_enq_addr       = r_front;

        if (r_show_active) begin
            // One read per cycle while the queue is not full, front to back
            if (!i_full) begin
                o_enq          = 1'b1;
                o_enq_ctl.kind = OP_READ;
                o_enq_ctl.last = (r_show_left == CW'(1));
                o_enq_addr     = r_show_addr;
                n_show_addr    = show_inc;
                n_show_left    = r_show_left - CW'(1);
                if (r_show_left == CW'(1)) begin
                    n_show_active = 1'b0;
                end
            end
        end else if (accept) begin
            unique case (i_action)
                ACT_PUSH_FRONT: begin
                    o_enq = 1'b1;
                    if (is_full) begin
                        o_enq_ctl.status = ST_FULL;
                    end else begin
                        o_enq_ctl.kind = OP_WRITE;
                        o_enq_addr     = front_dec;
                        n_front        = front_dec;
                        n_count        = r_count + CW'(1);
                    end
                end
                ACT_PUSH_BACK: begin
                    o_enq = 1'b1;
                    if (is_full) begin
                        o_enq_ctl.status = ST_FULL;
                    end else begin
                        o_enq_ctl.kind = OP_WRITE;
                        o_enq_addr     = back_idx;
                        n_count        = r_count + CW'(1);
                    end
                end
                ACT_SHOW: begin
                    if (is_empty) begin
                        o_enq            = 1'b1;
                        o_enq_ctl.status = ST_EMPTY;
                    end else begin
                        n_show_active = 1'b1;
                        n_show_addr   = r_front;
                        n_show_left   = r_count;
                    end
                end
                ACT_POP_FRONT: begin
                    o_enq = 1'b1;
                    if (is_empty) begin
                        o_enq_ctl.status = ST_EMPTY;
                    end else begin
                        n_front = front_inc;
                        n_count = r_count - CW'(1);
                    end
                end
                ACT_POP_BACK: begin
                    o_enq = 1'b1;
                    if (is_empty) begin
                        o_enq_ctl.status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    // unknown action: no effect
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front       <= '0;
            r_count       <= '0;
            r_show_active <= 1'b0;
            r_show_left   <= '0;
        end else begin
            r_front       <= n_front;
            r_count       <= n_count;
            r_show_active <= n_show_active;
            r_show_left   <= n_show_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_show_addr <= n_show_addr;
    end

    // Checks
    `BDQ_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(DEPTH))
    `BDQ_ASSERT_NOW(a_show_nonempty, r_show_active, r_show_left != '0 && r_count != '0)
    `BDQ_ASSERT_NOW(a_enq_has_room, o_enq, !i_full)
    `BDQ_ASSERT_NEXT(a_show_stall_hold, r_show_active && !o_enq,
                     r_show_left == $past(r_show_left) && r_show_active)

endmodule

### rtl/bdq_back.sv
// ----------------------------------------------------------------------------
// bdq_back
// Holds the entry store, carries out queued writes and reads, and drives
// the registered result strobe.
// ----------------------------------------------------------------------------
module bdq_back
    import bdq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_ctl                   i_ctl,
    input  logic [AW-1:0]          i_addr,
    input  logic [VALUE_WIDTH-1:0] i_data,
    output logic                   o_valid,
    output logic signed [31:0]     o_item_value,
    output logic [STATUS_W-1:0]    o_status,
    output logic                   o_last_of_run
);

    logic [VALUE_WIDTH-1:0] r_store [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   r_valid;
    logic                   r_is_read;
    logic [STATUS_W-1:0]    r_status;
    logic                   r_last;
    logic [63:0]            rd_wide;

    // Entry store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_valid && i_ctl.kind == OP_WRITE) begin
            r_store[i_addr] <= i_data;
        end
        if (i_valid && i_ctl.kind == OP_READ) begin
            r_rd_data <= r_store[i_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_read <= (i_ctl.kind == OP_READ);
        r_status  <= i_ctl.status;
        r_last    <= i_ctl.last;
    end

    assign rd_wide       = 64'(r_rd_data);
    assign o_valid       = r_valid;
    assign o_item_value  = r_is_read ? rd_wide[ITEM_W-1:0] : '0;
    assign o_status      = r_status;
    assign o_last_of_run = r_last;

endmodule

### rtl/bounded_deque.sv
// Push and pop: queued, then registered result; one command per cycle while not busy.
// Show of N entries: N results, one per cycle unless stalled; busy until the last read.
// Empty show, pop on empty, push on full: one status result, by the same path.
// The pace is set by the single-port entry store, one access per cycle.
// Synchronous active-low reset empties the deque; stored values are not cleared.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed values in a ring of DEPTH entries, with
// push/pop at both ends and a show command that lists all entries.
// ----------------------------------------------------------------------------
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic signed [31:0]  i_value,
    output logic                o_valid,
    output logic signed [31:0]  o_item_value,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_last_of_run
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int QW = $bits(t_ctl) + AW + VALUE_WIDTH;

    logic                   enq;
    t_ctl                   enq_ctl;
    logic [AW-1:0]          enq_addr;
    logic [VALUE_WIDTH-1:0] enq_data;
    logic                   q_full;
    logic                   q_valid;
    logic [QW-1:0]          q_data;
    t_ctl                   op_ctl;
    logic [AW-1:0]          op_addr;
    logic [VALUE_WIDTH-1:0] op_data;

    // Front end: command decode, ring pointers
    bdq_front #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .CW          (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .o_busy     (busy),
        .i_action   (i_action),
        .i_value    (i_value),
        .i_full     (q_full),
        .o_enq      (enq),
        .o_enq_ctl  (enq_ctl),
        .o_enq_addr (enq_addr),
        .o_enq_data (enq_data)
    );

    // Operation queue
    bdq_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (enq),
        .i_data  ({enq_ctl, enq_addr, enq_data}),
        .o_full  (q_full),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign {op_ctl, op_addr, op_data} = q_data;

    // Back end: entry store and result register
    bdq_back #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_ctl         (op_ctl),
        .i_addr        (op_addr),
        .i_data        (op_data),
        .o_valid       (o_valid),
        .o_item_value  (o_item_value),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

endmodule
